FILE: hdl/lfu_oldest_slot_replacement_macros.svh
// Assertion macros for the replacement block's controller.
`ifndef LFU_OLDEST_SLOT_REPLACEMENT_MACROS_SVH
`define LFU_OLDEST_SLOT_REPLACEMENT_MACROS_SVH

// Checks a property on every rising edge of clk while reset is released.
`define LFUOS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define LFUOS_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

FILE: hdl/lfuos_pkg.sv
// Types and constants shared by the replacement block's modules.
`default_nettype none

package lfuos_pkg;

	localparam int ID_W       = 16;
	localparam int HITS_W     = 16;
	localparam int STAMP_W    = 32;
	localparam int CFG_W      = 5;
	localparam int OUTCOME_W  = 2;
	localparam int SLOT_OUT_W = 4;

	localparam logic [CFG_W-1:0]     FRAMES_RESET = 5'd16;
	localparam logic [HITS_W-1:0]    HITS_MAX     = 16'hFFFF;
	localparam logic [STAMP_W-1:0]   STAMP_MAX    = 32'hFFFF_FFFF;

	localparam logic [OUTCOME_W-1:0] OUTCOME_HIT     = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_PLACE   = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_REPLACE = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]    tag;
		logic [HITS_W-1:0]  hits;
		logic [STAMP_W-1:0] stamp;
	} lfuos_entry_t;

	typedef struct packed {
		logic start;
		logic read;
		logic update;
	} lfuos_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic filled_zero;
		logic out_busy;
	} lfuos_sts_t;

endpackage

`default_nettype wire

FILE: hdl/lfuos_datapath.sv
// Slot store, scan compare, victim tracking, update logic and result register.
`default_nettype none

module lfuos_datapath import lfuos_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lfuos_cmd_t            cmd,
	output lfuos_sts_t                 sts,
	input  wire logic [ID_W-1:0]       candidate_id,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_W-1:0]      frames_in_use,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic [OUTCOME_W-1:0]       outcome,
	output logic [SLOT_OUT_W-1:0]      slot_index,
	output logic [ID_W-1:0]            evicted_id,
	output logic [HITS_W-1:0]          new_count
);

	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

	lfuos_entry_t mem_q [SLOTS];

	logic [ID_W-1:0]    id_q;
	logic [IW-1:0]      cnt_q;
	logic [CW-1:0]      filled_q;
	logic [STAMP_W-1:0] clock_q;
	logic [CFG_W-1:0]   frames_q;

	lfuos_entry_t       rd_data_s1;
	logic [IW-1:0]      rd_addr_s1;
	logic               rd_valid_s1;

	logic               found_q;
	logic [IW-1:0]      hit_idx_q;
	lfuos_entry_t       hit_entry_q;
	logic [IW-1:0]      vic_idx_q;
	lfuos_entry_t       vic_entry_q;

	logic               out_valid_q;
	logic [OUTCOME_W-1:0]  outcome_q;
	logic [SLOT_OUT_W-1:0] slot_index_q;
	logic [ID_W-1:0]       evicted_id_q;
	logic [HITS_W-1:0]     new_count_q;

	logic               take_hit;
	logic               take_vic;
	logic [CFG_W-1:0]   lim_lo;
	logic               place;
	logic [IW-1:0]      wr_idx;
	lfuos_entry_t       wr_entry;
	logic [OUTCOME_W-1:0] res_outcome;
	logic [ID_W-1:0]    res_evicted;

	assign take_hit = (rd_data_s1.tag == id_q) && !found_q;
	assign take_vic = (rd_addr_s1 == '0) ||
		(rd_data_s1.hits < vic_entry_q.hits) ||
		((rd_data_s1.hits == vic_entry_q.hits) && (rd_data_s1.stamp < vic_entry_q.stamp));

	assign lim_lo = (frames_q == '0) ? CFG_W'(1) : frames_q;
	assign place  = (CMP_W'(filled_q) < CMP_W'(lim_lo)) && (filled_q < CW'(SLOTS));

	always_comb begin
		wr_idx      = vic_idx_q;
		wr_entry    = '{tag: id_q, hits: HITS_W'(1), stamp: clock_q};
		res_outcome = OUTCOME_REPLACE;
		res_evicted = vic_entry_q.tag;
		if (found_q) begin
			wr_idx      = hit_idx_q;
			wr_entry    = hit_entry_q;
			if (hit_entry_q.hits != HITS_MAX) begin
				wr_entry.hits = hit_entry_q.hits + HITS_W'(1);
			end
			res_outcome = OUTCOME_HIT;
			res_evicted = '0;
		end else if (place) begin
			wr_idx      = IW'(filled_q);
			res_outcome = OUTCOME_PLACE;
			res_evicted = '0;
		end
	end

	assign sts.scan_last   = ((CW'(cnt_q) + CW'(1)) == filled_q);
	assign sts.filled_zero = (filled_q == '0);
	assign sts.out_busy    = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			filled_q    <= '0;
			clock_q     <= '0;
			frames_q    <= FRAMES_RESET;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.read;
			if (cfg_valid) begin
				frames_q <= frames_in_use;
			end
			if (cmd.start) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.read) begin
				cnt_q <= cnt_q + IW'(1);
			end
			if (rd_valid_s1 && take_hit) begin
				found_q <= 1'b1;
			end
			if (cmd.update) begin
				out_valid_q <= 1'b1;
				if (clock_q != STAMP_MAX) begin
					clock_q <= clock_q + STAMP_W'(1);
				end
				if (!found_q && place) begin
					filled_q <= filled_q + CW'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			id_q <= candidate_id;
		end
		if (cmd.read) begin
			rd_data_s1 <= mem_q[cnt_q];
			rd_addr_s1 <= cnt_q;
		end
		if (cmd.update) begin
			mem_q[wr_idx] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			if (take_hit) begin
				hit_idx_q   <= rd_addr_s1;
				hit_entry_q <= rd_data_s1;
			end
			if (take_vic) begin
				vic_idx_q   <= rd_addr_s1;
				vic_entry_q <= rd_data_s1;
			end
		end
		if (cmd.update) begin
			outcome_q    <= res_outcome;
			slot_index_q <= SLOT_OUT_W'(wr_idx);
			evicted_id_q <= res_evicted;
			new_count_q  <= wr_entry.hits;
		end
	end

	assign out_valid  = out_valid_q;
	assign outcome    = outcome_q;
	assign slot_index = slot_index_q;
	assign evicted_id = evicted_id_q;
	assign new_count  = new_count_q;

endmodule

`default_nettype wire

FILE: hdl/lfuos_ctrl.sv
// Controller that sequences the slot scan and the update for each request.
`default_nettype none
`include "lfu_oldest_slot_replacement_macros.svh"

module lfuos_ctrl import lfuos_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire lfuos_sts_t sts,
	output lfuos_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_UPDATE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.start  = (state_q == ST_IDLE) && in_valid;
		cmd.read   = (state_q == ST_SCAN);
		cmd.update = (state_q == ST_UPDATE) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= sts.filled_zero ? ST_UPDATE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`LFUOS_ASSERT(a_update_when_free, (cmd.update |-> !sts.out_busy), "result overwritten while held")
	`LFUOS_ASSERT(a_cmd_exclusive, $onehot0({cmd.start, cmd.read, cmd.update}), "commands overlap")
	`LFUOS_ASSERT_NEXT(a_scan_end, state_q == ST_SCAN && sts.scan_last, state_q == ST_WAIT, "scan overran")
	`LFUOS_ASSERT_NEXT(a_start_scan, cmd.start && !sts.filled_zero, state_q == ST_SCAN, "scan not started")

endmodule

`default_nettype wire

FILE: hdl/lfu_oldest_slot_replacement.sv
// Each request that is accepted goes through the scan of the filled slots, a wait state and the update.
// With no slot filled the scan is skipped and the request goes straight to the update.
// The update waits while an earlier result is still held; a new request is accepted only in idle.
// The slot store is read one slot per cycle during the scan.
// A result may wait at the output while the next request is accepted and scanned.
// Reset empties every slot, clears the step clock and sets frames_in_use to sixteen.
`default_nettype none

module lfu_oldest_slot_replacement import lfuos_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [ID_W-1:0]       candidate_id,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUTCOME_W-1:0]       outcome,
	output logic [SLOT_OUT_W-1:0]      slot_index,
	output logic [ID_W-1:0]            evicted_id,
	output logic [HITS_W-1:0]          new_count,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_W-1:0]      frames_in_use
);

	lfuos_cmd_t cmd;
	lfuos_sts_t sts;

	assign cfg_ready = 1'b1;

	lfuos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfuos_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.candidate_id  (candidate_id),
		.cfg_valid     (cfg_valid),
		.frames_in_use (frames_in_use),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.outcome       (outcome),
		.slot_index    (slot_index),
		.evicted_id    (evicted_id),
		.new_count     (new_count)
	);

endmodule

`default_nettype wire

FILE: dv/tb_lfu_oldest_slot_replacement.sv
// Self-checking testbench for the least-frequently-used slot replacement block.

typedef struct packed {
	logic [lfuos_pkg::OUTCOME_W-1:0]  outcome;
	logic [lfuos_pkg::SLOT_OUT_W-1:0] slot;
	logic [lfuos_pkg::ID_W-1:0]       evicted;
	logic [lfuos_pkg::HITS_W-1:0]     count;
} slot_result_t;

class slot_table_model;
	localparam int NUM_SLOTS = 16;

	bit                            occupied [NUM_SLOTS];
	logic [lfuos_pkg::ID_W-1:0]    tag_of [NUM_SLOTS];
	logic [lfuos_pkg::HITS_W-1:0]  hits_of [NUM_SLOTS];
	logic [lfuos_pkg::STAMP_W-1:0] stamp_of [NUM_SLOTS];
	int unsigned                   filled;
	logic [lfuos_pkg::STAMP_W-1:0] step_now;
	logic [lfuos_pkg::CFG_W-1:0]   frame_limit;
	slot_result_t                  pending[$];
	int                            mismatches;

	function new();
		foreach (occupied[i]) begin
			occupied[i] = 1'b0;
			tag_of[i] = '0;
			hits_of[i] = '0;
			stamp_of[i] = '0;
		end
		filled = 0;
		step_now = '0;
		frame_limit = lfuos_pkg::FRAMES_RESET;
		mismatches = 0;
	endfunction

	function void set_frames(logic [lfuos_pkg::CFG_W-1:0] value);
		frame_limit = value;
	endfunction

	function void note_request(logic [lfuos_pkg::ID_W-1:0] id);
		slot_result_t res;
		int unsigned limit;
		int unsigned slot;
		bit found;
		found = 1'b0;
		slot = 0;
		res.evicted = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!found && occupied[i] && tag_of[i] == id) begin
				found = 1'b1;
				slot = i;
			end
		end
		limit = (frame_limit == 0) ? 1 : frame_limit;
		if (limit > NUM_SLOTS)
			limit = NUM_SLOTS;
		if (found) begin
			if (hits_of[slot] != lfuos_pkg::HITS_MAX)
				hits_of[slot] = hits_of[slot] + 1'b1;
			res.outcome = lfuos_pkg::OUTCOME_HIT;
		end else begin
			if (filled < limit) begin
				slot = filled;
				filled++;
				res.outcome = lfuos_pkg::OUTCOME_PLACE;
			end else begin
				slot = 0;
				for (int i = 1; i < filled && i < NUM_SLOTS; i++) begin
					if (hits_of[i] < hits_of[slot] ||
						(hits_of[i] == hits_of[slot] && stamp_of[i] < stamp_of[slot]))
						slot = i;
				end
				res.evicted = tag_of[slot];
				res.outcome = lfuos_pkg::OUTCOME_REPLACE;
			end
			occupied[slot] = 1'b1;
			tag_of[slot] = id;
			hits_of[slot] = lfuos_pkg::HITS_W'(1);
			stamp_of[slot] = step_now;
		end
		res.slot = slot[lfuos_pkg::SLOT_OUT_W-1:0];
		res.count = hits_of[slot];
		if (step_now != lfuos_pkg::STAMP_MAX)
			step_now = step_now + 1'b1;
		pending.insert(pending.size(), res);
	endfunction

	task report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task check_result(slot_result_t got);
		slot_result_t want;
		if (pending.size() == 0) begin
			report_mismatch($sformatf("unexpected result %p", got));
		end else begin
			want = pending.pop_front();
			if (got.outcome !== want.outcome)
				report_mismatch($sformatf("outcome %0d, wanted %0d", got.outcome, want.outcome));
			if (got.slot !== want.slot)
				report_mismatch($sformatf("slot_index %0d, wanted %0d", got.slot, want.slot));
			if (got.evicted !== want.evicted)
				report_mismatch($sformatf("evicted_id %h, wanted %h", got.evicted, want.evicted));
			if (got.count !== want.count)
				report_mismatch($sformatf("new_count %0d, wanted %0d", got.count, want.count));
		end
	endtask
endclass

module tb_lfu_oldest_slot_replacement import lfuos_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 24;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [ID_W-1:0]       candidate_id = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [OUTCOME_W-1:0]  outcome;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic [ID_W-1:0]       evicted_id;
	logic [HITS_W-1:0]     new_count;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      frames_in_use = '0;

	slot_table_model model = new();

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	lfu_oldest_slot_replacement #(
		.SLOTS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.candidate_id(candidate_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.outcome(outcome),
		.slot_index(slot_index),
		.evicted_id(evicted_id),
		.new_count(new_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.frames_in_use(frames_in_use)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		slot_result_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				model.set_frames(frames_in_use);
			if (in_valid && in_ready)
				model.note_request(candidate_id);
			if (out_valid && out_ready) begin
				got.outcome = outcome;
				got.slot = slot_index;
				got.evicted = evicted_id;
				got.count = new_count;
				model.check_result(got);
			end
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task send_request(logic [ID_W-1:0] id);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		candidate_id <= id;
		do @(posedge clk); while (!in_ready);
	endtask

	task drain_results();
		in_valid <= 1'b0;
		while (model.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task set_frame_limit(logic [CFG_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		frames_in_use <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ID_W-1:0] pick_id();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return ID_W'(16'h0C00 + $urandom_range(3));
		else if (r < 80)
			return ID_W'(16'h1000 + $urandom_range(23));
		else
			return ID_W'($urandom_range(65535));
	endfunction

	task run_phase(logic [CFG_W-1:0] frames, int idle_pct, int stall_pct, int items,
		int hold);
		set_frame_limit(frames);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		if (hold > 0)
			hold_request = hold;
		repeat (items) send_request(pick_id());
		drain_results();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A limit of zero behaves as a single slot.
		set_frame_limit(5'd0);
		send_request(16'h0000);
		send_request(16'h0000);
		send_request(16'hFFFF);
		repeat (4) send_request(16'hFFFF);
		send_request(16'h5A5A);

		// Three slots: repeated IDs count as hits and the slot with the fewest hits is replaced.
		set_frame_limit(5'd3);
		send_request(16'hA5A5);
		send_request(16'h0001);
		send_request(16'hA5A5);
		send_request(16'h8000);
		send_request(16'h0001);
		send_request(16'h7FFF);

		// A limit above the slot count behaves as the full table.
		set_frame_limit(5'd31);
		send_request(16'h0000);
		send_request(16'h00FF);
		send_request(16'hFF00);
		send_request(16'h1234);
		send_request(16'hFFFF);
		send_request(16'h0000);

		run_phase(5'd31, 0, 0, 200, 0);
		run_phase(5'd16, 83, 0, 200, 0);
		run_phase(5'd2, 0, 83, 200, 0);
		run_phase(5'd16, 0, 0, 200, 400);
		run_phase(5'd1, 30, 30, 200, 0);
		run_phase(5'd24, 0, 0, 200, 0);
		run_phase(5'd7, 83, 0, 200, 0);
		run_phase(5'd16, 30, 30, 200, 0);

		if (model.mismatches == 0 && model.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
